>>> sv/bel_pkg.sv
// Shared widths, codes and types of the bin edge locate and sample block.
package bel_pkg;

	localparam int DEF_MAX_EDGES  = 1024;
	localparam int DEF_VALUE_BITS = 32;

	localparam int KIND_BITS    = 2;
	localparam int SLOT_BITS    = 10;
	localparam int FRAC_BITS    = 16;
	localparam int COUNT_BITS   = 11;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [KIND_BITS-1:0] KIND_WRITE  = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_LOCATE = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_SAMPLE = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_EDGE   = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_COUNT = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SAMP_HI,
		S_SAMP_LO,
		S_INTERP,
		S_FINISH
	} state_t;

endpackage

>>> sv/bel_cfg_if.sv
// Configuration write channel: register index and write data.
interface bel_cfg_if import bel_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
);
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [VALUE_BITS-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/bel_req_if.sv
// Request channel: write edge, locate value or sample within a bin.
interface bel_req_if import bel_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
);
	logic                  valid;
	logic                  ready;
	logic [KIND_BITS-1:0]  kind;
	logic [SLOT_BITS-1:0]  slot;
	logic [VALUE_BITS-1:0] value;
	logic [FRAC_BITS-1:0]  fraction;

	modport source (output valid, output kind, output slot, output value, output fraction,
		input ready);
	modport sink   (input valid, input kind, input slot, input value, input fraction,
		output ready);
endinterface

>>> sv/bel_rsp_if.sv
// Response channel: locate or sample answer.
interface bel_rsp_if import bel_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
);
	logic                  valid;
	logic                  ready;
	logic [KIND_BITS-1:0]  answer_kind;
	logic [COUNT_BITS-1:0] bin_index;
	logic [VALUE_BITS-1:0] sample_value;
	logic                  index_error;

	modport source (output valid, output answer_kind, output bin_index, output sample_value,
		output index_error, input ready);
	modport sink   (input valid, input answer_kind, input bin_index, input sample_value,
		input index_error, output ready);
endinterface

>>> sv/bel_ram.sv
// Generic single write port, single read port RAM with registered read data.
module bel_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/bel_cell.sv
// One probe cell of the upper bound search chain.
module bel_cell #(
	parameter int CNT_W      = 11,
	parameter int ADDR_W     = 10,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_v,
	input  logic [CNT_W-1:0]      in_lo,
	input  logic [CNT_W-1:0]      in_hi,
	input  logic [VALUE_BITS-1:0] key,
	input  logic [VALUE_BITS-1:0] rdata,
	output logic                  out_v,
	output logic [CNT_W-1:0]      out_lo,
	output logic [CNT_W-1:0]      out_hi,
	output logic [ADDR_W-1:0]     rd_addr
);

	logic             v_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] mid;
	logic [CNT_W-1:0] next_mid;
	logic             active;
	logic             above;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= in_lo;
		hi_q <= in_hi;
	end

	// The read data is the edge at this cell's midpoint; the previous cell
	// issued that address in the previous cycle.
	always_comb begin
		mid      = lo_q + ((hi_q - lo_q) >> 1);
		active   = lo_q < hi_q;
		above    = $signed(rdata) > $signed(key);
		out_lo   = (active && !above) ? mid + CNT_W'(1) : lo_q;
		out_hi   = (active && above) ? mid : hi_q;
		next_mid = out_lo + ((out_hi - out_lo) >> 1);
		rd_addr  = next_mid[ADDR_W-1:0];
		out_v    = v_q;
	end

endmodule

>>> sv/bel_interp.sv
// Interpolation unit: lo + floor((hi - lo) * frac / 2^16), one 16-bit digit per cycle.
module bel_interp import bel_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] lo,
	input  logic [VALUE_BITS-1:0] hi,
	input  logic [FRAC_BITS-1:0]  frac,
	output logic                  done,
	output logic [VALUE_BITS-1:0] result
);

	localparam int ND  = (VALUE_BITS + FRAC_BITS - 1) / FRAC_BITS;
	localparam int MW  = ND * FRAC_BITS;
	localparam int PW  = MW + FRAC_BITS;
	localparam int CNW = $clog2(ND + 1);
	localparam logic [CNW-1:0] LAST = CNW'(ND - 1);

	logic                   run_q;
	logic                   fin_q;
	logic [CNW-1:0]         cnt_q;
	logic                   up_q;
	logic [VALUE_BITS-1:0]  lo_q;
	logic [FRAC_BITS-1:0]   f_q;
	logic [MW-1:0]          mag_q;
	logic [PW-1:0]          acc_q;

	logic                   up;
	logic [VALUE_BITS:0]    diff;
	logic [2*FRAC_BITS-1:0] prod;
	logic [PW-1:0]          acc_next;
	logic [VALUE_BITS-1:0]  quot;
	logic                   rem_nz;

	always_comb begin
		up = !($signed(lo) > $signed(hi));
		if (up) begin
			diff = {hi[VALUE_BITS-1], hi} - {lo[VALUE_BITS-1], lo};
		end else begin
			diff = {lo[VALUE_BITS-1], lo} - {hi[VALUE_BITS-1], hi};
		end
	end

	// Digits of the magnitude are taken most significant first.
	assign prod     = mag_q[MW-1 -: FRAC_BITS] * f_q;
	assign acc_next = {acc_q[PW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}} + PW'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + CNW'(1);
			if (cnt_q == LAST) begin
				run_q <= 1'b0;
				fin_q <= 1'b1;
			end
		end else begin
			fin_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			up_q  <= up;
			lo_q  <= lo;
			f_q   <= frac;
			mag_q <= MW'(diff[VALUE_BITS-1:0]);
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_next;
			mag_q <= mag_q << FRAC_BITS;
		end
	end

	// Going down, a nonzero remainder pushes the floor one step further.
	always_comb begin
		quot   = acc_q[FRAC_BITS +: VALUE_BITS];
		rem_nz = |acc_q[FRAC_BITS-1:0];
		if (up_q) begin
			result = lo_q + quot;
		end else begin
			result = lo_q - quot - VALUE_BITS'(rem_nz);
		end
	end

	assign done = fin_q;

endmodule

>>> sv/bin_edge_locate_and_sample.sv
// Top level of the bin edge locate and sample block.
//
// Channels: cfg writes min_edge (index 0) or edge_count (index 1) and is
// always ready. req carries one item per beat: kind 0 stores value as edge
// slot, kind 1 locates the first edge above value, kind 2 samples inside bin
// slot with fraction. rsp returns one beat for each locate and sample item.
// Write items and the unused kind finish in the accepting cycle and return
// nothing. req is ready whenever no item is in progress.
// Locate runs a row of probe cells, one per search step, that take one edge
// table read per cycle from the single RAM read port.
// Sample takes two table reads, then one 16 by 16 partial product per cycle.
// An index error or a single edge in use goes straight to the finish state.
// A finished answer sits in the rsp register; the next item is accepted while
// it waits. If the receiver stalls, a further answer waits in the block and
// req stays low until the register frees.
// Reset sets min_edge to the most negative value and edge_count to 1. The
// edge table is not cleared; edges must be written before they are read.
module bin_edge_locate_and_sample import bel_pkg::*; #(
	parameter int MAX_EDGES  = DEF_MAX_EDGES,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	bel_cfg_if.sink   cfg,
	bel_req_if.sink   req,
	bel_rsp_if.source rsp
);

	localparam int AW    = $clog2(MAX_EDGES);
	localparam int CW    = $clog2(MAX_EDGES + 1);
	localparam int STEPS = CW;
	localparam int IW    = (CW > COUNT_BITS) ? CW : COUNT_BITS;
	localparam int YW    = IW + 1;

	state_t state_q;
	state_t state_d;

	logic [VALUE_BITS-1:0] min_edge_q;
	logic [COUNT_BITS-1:0] edge_count_q;

	logic [VALUE_BITS-1:0] key_q;
	logic [SLOT_BITS-1:0]  slot_q;
	logic [FRAC_BITS-1:0]  frac_q;
	logic [VALUE_BITS-1:0] hi_q;

	logic [KIND_BITS-1:0]  pend_kind_q;
	logic [COUNT_BITS-1:0] pend_idx_q;
	logic [VALUE_BITS-1:0] pend_val_q;
	logic                  pend_err_q;

	logic                  rsp_valid_q;
	logic [KIND_BITS-1:0]  rsp_kind_q;
	logic [COUNT_BITS-1:0] rsp_idx_q;
	logic [VALUE_BITS-1:0] rsp_val_q;
	logic                  rsp_err_q;

	logic [YW-1:0] count_y;
	logic [YW-1:0] max_y;
	logic [YW-1:0] n_y;
	logic [YW-1:0] slot_y;
	logic [YW-1:0] slot_m1_y;
	logic [CW-1:0] n_in_use;
	logic          n_one;
	logic          slot_err;
	logic          write_ok;
	logic          accept;
	logic          out_load;

	logic                  req_ready;
	logic                  ram_we;
	logic [AW-1:0]         ram_raddr;
	logic [VALUE_BITS-1:0] ram_rdata;
	logic                  chain_start;
	logic                  interp_start;
	logic                  interp_done;
	logic [VALUE_BITS-1:0] interp_result;
	logic [VALUE_BITS-1:0] lo_sel;

	logic [STEPS:0] link_v;
	logic [CW-1:0]  link_lo   [STEPS+1];
	logic [CW-1:0]  link_hi   [STEPS+1];
	logic [AW-1:0]  cell_addr [STEPS];
	logic [STEPS-1:0] cell_v;
	logic [AW-1:0]  search_addr;
	logic [IW-1:0]  idx_w;

	// Edges in use saturate at the table depth.
	always_comb begin
		count_y   = YW'(edge_count_q);
		max_y     = YW'(MAX_EDGES);
		n_y       = (count_y > max_y) ? max_y : count_y;
		n_in_use  = n_y[CW-1:0];
		n_one     = n_y == YW'(1);
		slot_y    = YW'(req.slot);
		slot_m1_y = YW'(slot_q) - YW'(1);
		slot_err  = slot_y >= n_y;
		write_ok  = slot_y < max_y;
		accept    = req.valid && req_ready;
		out_load  = (state_q == S_FINISH) && (!rsp_valid_q || rsp.ready);
		lo_sel    = (slot_q == '0) ? min_edge_q : ram_rdata;
		idx_w     = IW'(link_lo[STEPS]);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (req.kind)
						KIND_LOCATE: state_d = n_one ? S_FINISH : S_SEARCH;
						KIND_SAMPLE: state_d = (slot_err || n_one) ? S_FINISH : S_SAMP_HI;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_SEARCH:  state_d = link_v[STEPS] ? S_FINISH : S_SEARCH;
			S_SAMP_HI: state_d = S_SAMP_LO;
			S_SAMP_LO: state_d = S_INTERP;
			S_INTERP:  state_d = interp_done ? S_FINISH : S_INTERP;
			S_FINISH:  state_d = out_load ? S_IDLE : S_FINISH;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready    = 1'b0;
		ram_we       = 1'b0;
		ram_raddr    = '0;
		chain_start  = 1'b0;
		interp_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				ram_we      = req.valid && (req.kind == KIND_WRITE) && write_ok;
				chain_start = req.valid && (req.kind == KIND_LOCATE) && !n_one;
				if (req.kind == KIND_SAMPLE) begin
					ram_raddr = slot_y[AW-1:0];
				end else begin
					ram_raddr = n_y[AW:1];
				end
			end
			S_SEARCH:  ram_raddr = search_addr;
			S_SAMP_HI: ram_raddr = slot_m1_y[AW-1:0];
			S_SAMP_LO: interp_start = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rsp_valid_q  <= 1'b0;
			min_edge_q   <= {1'b1, {(VALUE_BITS-1){1'b0}}};
			edge_count_q <= COUNT_BITS'(1);
		end else begin
			state_q <= state_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MIN_EDGE:   min_edge_q   <= cfg.data;
					REG_EDGE_COUNT: edge_count_q <= cfg.data[COUNT_BITS-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_q       <= req.value;
					slot_q      <= req.slot;
					frac_q      <= req.fraction;
					pend_kind_q <= req.kind;
					pend_idx_q  <= '0;
					pend_val_q  <= '0;
					pend_err_q  <= (req.kind == KIND_SAMPLE) && slot_err;
				end
			end
			S_SEARCH: begin
				if (link_v[STEPS]) begin
					pend_idx_q <= idx_w[COUNT_BITS-1:0];
				end
			end
			S_SAMP_HI: hi_q <= ram_rdata;
			S_INTERP: begin
				if (interp_done) begin
					pend_val_q <= interp_result;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			rsp_kind_q <= pend_kind_q;
			rsp_idx_q  <= pend_idx_q;
			rsp_val_q  <= pend_val_q;
			rsp_err_q  <= pend_err_q;
		end
	end

	bel_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (MAX_EDGES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_y[AW-1:0]),
		.wdata (req.value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign link_v[0]  = chain_start;
	assign link_lo[0] = '0;
	assign link_hi[0] = n_in_use;

	for (genvar k = 0; k < STEPS; k++) begin : g_cell
		bel_cell #(
			.CNT_W      (CW),
			.ADDR_W     (AW),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_v    (link_v[k]),
			.in_lo   (link_lo[k]),
			.in_hi   (link_hi[k]),
			.key     (key_q),
			.rdata   (ram_rdata),
			.out_v   (link_v[k+1]),
			.out_lo  (link_lo[k+1]),
			.out_hi  (link_hi[k+1]),
			.rd_addr (cell_addr[k])
		);
	end

	assign cell_v = link_v[STEPS:1];

	// Only one cell holds the item, so its probe address wins the OR.
	always_comb begin
		search_addr = '0;
		for (int k = 0; k < STEPS; k++) begin
			if (cell_v[k]) begin
				search_addr = search_addr | cell_addr[k];
			end
		end
	end

	bel_interp #(
		.VALUE_BITS (VALUE_BITS)
	) u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (interp_start),
		.lo     (lo_sel),
		.hi     (hi_q),
		.frac   (frac_q),
		.done   (interp_done),
		.result (interp_result)
	);

	assign req.ready        = req_ready;
	assign cfg.ready        = 1'b1;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.answer_kind  = rsp_kind_q;
	assign rsp.bin_index    = rsp_idx_q;
	assign rsp.sample_value = rsp_val_q;
	assign rsp.index_error  = rsp_err_q;

`ifndef ASSERT_OFF
	a_one_cell_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_v))
		else $error("more than one search cell holds an item");

	a_cells_only_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(|cell_v) |-> (state_q == S_SEARCH))
		else $error("search cell active outside the search state");

	a_interp_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		interp_done |-> (state_q == S_INTERP))
		else $error("interpolation finished outside its wait state");

	a_locate_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_kind_q == KIND_LOCATE)) |-> (!rsp_err_q && (rsp_val_q == '0)))
		else $error("locate answer carries sample fields");

	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		chain_start |=> (state_q == S_SEARCH) && link_v[1])
		else $error("search start did not reach the first cell");
`endif

endmodule
